// File: rtl/flc_pkg.sv
// Package for the FIFO-replacement lookup cache.
// Holds sizes, operation codes and the result record; no dependencies.
package flc_pkg;

	localparam int CAPACITY    = 16;
	localparam int SLOT_BITS   = $clog2(CAPACITY);
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
	localparam int KEY_BITS    = 64;
	localparam int VALUE_BITS  = 64;
	localparam int LIMIT_BITS  = 5;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(CAPACITY);

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_FILL   = 1'b1;

	typedef struct packed {
		logic                  evicted;
		logic                  hit;
		logic [KEY_BITS-1:0]   evicted_key;
		logic [VALUE_BITS-1:0] read_value;
	} result_t;

endpackage

// File: rtl/fifo_replacement_lookup_cache.sv
// Fully associative key/value cache with oldest-first replacement.
// Depends on flc_pkg (sizes, operation codes, result record).
//
// A request passes through the input register, then the result register,
// before its result is shown on m_*.
// Throughput: one request per cycle while m_tready keeps the result register
// free; the combinational compare of all slots and one slot write per fill set this figure.
// Reset (arst_n low, asynchronous): all slots invalid, live count and oldest
// pointer zero, limit 16; stored keys and values are not cleared.
module fifo_replacement_lookup_cache (
	input  logic         clk,
	input  logic         arst_n,
	// request side
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // [63:0] key, [127:64] fill_value
	input  logic         s_tuser,  // [0] operation (0 lookup, 1 fill)
	// result side
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // [63:0] read_value, [127:64] evicted_key
	output logic [1:0]   m_tuser,  // [0] hit, [1] evicted
	// limit register write
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data  // capacity_limit
);

	localparam int NS = flc_pkg::SLOT_BITS;
	localparam int NC = flc_pkg::COUNT_BITS;
	localparam int KB = flc_pkg::KEY_BITS;
	localparam int VB = flc_pkg::VALUE_BITS;
	localparam int LB = flc_pkg::LIMIT_BITS;
	localparam int CAP = flc_pkg::CAPACITY;

	// input register
	logic          valid_s1;
	logic          op_s1;
	logic [KB-1:0] key_s1;
	logic [VB-1:0] value_s1;
	logic          advance;

	// cache state
	logic [CAP-1:0] entry_valid_q;
	logic [KB-1:0]  entry_keys_q   [CAP];
	logic [VB-1:0]  entry_values_q [CAP];
	logic [NS-1:0]  oldest_q;
	logic [NC-1:0]  live_q;
	logic [LB-1:0]  limit_q;

	// result register
	flc_pkg::result_t res_q;
	logic             res_valid_q;

	// single-pass logic
	logic [CAP-1:0] match;
	logic           found;
	logic [VB-1:0]  hit_value;
	logic [NC-1:0]  limit_eff;
	logic           is_fill;
	logic           fill_new;
	logic           need_evict;
	logic [NS-1:0]  oldest_next;
	logic [NC-1:0]  live_base;
	logic [NC:0]    dst_sum;
	logic [NS-1:0]  dst;
	flc_pkg::result_t res_d;

	// Result register frees when empty or taken; input stage follows it.
	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			key_s1   <= s_tdata[KB-1:0];
			value_s1 <= s_tdata[64 +: VB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= flc_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Limit of zero acts as one; anything above the slot count saturates.
	always_comb begin
		if (limit_q == '0) begin
			limit_eff = NC'(1);
		end else if (LB'(limit_q) > LB'(CAP)) begin
			limit_eff = NC'(CAP);
		end else begin
			limit_eff = NC'(limit_q);
		end
	end

	// Key compare across every live slot; keys are unique among live slots.
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAP; i++) begin
			match[i] = entry_valid_q[i] && (entry_keys_q[i] == key_s1);
			if (match[i]) begin
				hit_value = hit_value | entry_values_q[i];
			end
		end
		found = |match;
	end

	assign is_fill    = (op_s1 == flc_pkg::OP_FILL);
	assign fill_new   = is_fill && !found;
	assign need_evict = fill_new && (live_q >= limit_eff);

	// On eviction the ring head moves on by one and live_base, used for dst, drops by one.
	always_comb begin
		if (need_evict) begin
			oldest_next = (oldest_q == NS'(CAP - 1)) ? '0 : oldest_q + NS'(1);
			live_base   = live_q - NC'(1);
		end else begin
			oldest_next = oldest_q;
			live_base   = live_q;
		end
		dst_sum = (NC+1)'(oldest_next) + (NC+1)'(live_base);
		if (dst_sum >= (NC+1)'(CAP)) begin
			dst = NS'(dst_sum - (NC+1)'(CAP));
		end else begin
			dst = NS'(dst_sum);
		end
	end

	always_comb begin
		res_d.hit         = found;
		res_d.read_value  = (!is_fill && found) ? hit_value : '0;
		res_d.evicted     = need_evict;
		res_d.evicted_key = need_evict ? entry_keys_q[oldest_q] : '0;
	end

	// Control state of the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			oldest_q      <= '0;
			live_q        <= '0;
		end else if (advance && fill_new) begin
			for (int i = 0; i < CAP; i++) begin
				if (NS'(i) == dst) begin
					entry_valid_q[i] <= 1'b1;
				end else if (need_evict && NS'(i) == oldest_q) begin
					entry_valid_q[i] <= 1'b0;
				end
			end
			oldest_q <= oldest_next;
			if (!need_evict && live_q < NC'(CAP)) begin
				live_q <= live_q + NC'(1);
			end
		end
	end

	// Slot payload: new key at the young end, or in-place value update.
	always_ff @(posedge clk) begin
		if (advance && is_fill) begin
			for (int i = 0; i < CAP; i++) begin
				if (found) begin
					if (match[i]) begin
						entry_values_q[i] <= value_s1;
					end
				end else if (NS'(i) == dst) begin
					entry_keys_q[i]   <= key_s1;
					entry_values_q[i] <= value_s1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {res_q.evicted_key, res_q.read_value};
	assign m_tuser  = {res_q.evicted, res_q.hit};

	// checks
	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		NC'($countones(entry_valid_q)) == live_q)
		else $error("live count differs from valid slots");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= NC'(CAP))
		else $error("live count above capacity");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.evicted |-> !res_q.hit)
		else $error("eviction reported on a hit");

	a_evict_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && need_evict |=> $stable(live_q))
		else $error("eviction changed live count");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.hit |-> res_q.read_value == '0)
		else $error("value returned on a miss");

endmodule
